// ----- sv/pqsd_pkg.sv -----
package pqsd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W = 32;
    localparam int PRIO_W = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W = VALUE_W + PRIO_W;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQ = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic load_item;
        logic issue;
        logic scan;
        logic setup;
        logic shift;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_deq;
        logic empty;
        logic last_issue;
        logic best_is_last;
        logic out_busy;
    } sts_t;

endpackage

// ----- sv/pqsd_ctrl.sv -----
module pqsd_ctrl
    import pqsd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SCAN_DRAIN = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_SHIFT_DRAIN = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (sts.in_deq && !sts.empty) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                cmd.issue = 1'b1;
                cmd.scan = 1'b1;
                if (sts.last_issue) begin
                    state_next = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN: begin
                cmd.scan = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                if (sts.best_is_last) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.issue = 1'b1;
                cmd.shift = 1'b1;
                if (sts.last_issue) begin
                    state_next = S_SHIFT_DRAIN;
                end
            end
            S_SHIFT_DRAIN: begin
                cmd.shift = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/pqsd_dpath.sv -----
module pqsd_dpath
    import pqsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_action,
    input  logic signed [VALUE_W-1:0]  s_value_in,
    input  logic        [PRIO_W-1:0]   s_priority_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic        [STATUS_W-1:0] m_status,
    output logic signed [VALUE_W-1:0]  m_value_out,
    output logic        [PRIO_W-1:0]   m_priority_out,
    input  cmd_t                       cmd,
    output sts_t                       sts
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic                act_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [PRIO_W-1:0]   pri_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       rd_idx_reg;
    logic [IW-1:0]       rd_tag_reg;
    logic                rd_vld_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [IW-1:0]       best_idx_reg;
    logic [PRIO_W-1:0]   best_pri_reg;
    logic [VALUE_W-1:0]  best_val_reg;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  vout_reg;
    logic [PRIO_W-1:0]   pout_reg;

    logic [CW-1:0]      count_last;
    logic               empty, full, commit, take;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;

    assign count_last = count_reg - CW'(1);
    assign empty = (count_reg == '0);
    assign full = (count_reg == CW'(QUEUE_DEPTH));
    assign commit = cmd.finish && !sts.out_busy;
    assign take = cmd.scan && rd_vld_reg &&
                  ((rd_tag_reg == '0) || (rd_data_reg[ENTRY_W-1:VALUE_W] > best_pri_reg));

    assign sts.in_deq = (s_action == ACT_DEQ);
    assign sts.empty = empty;
    assign sts.last_issue = (CW'(rd_idx_reg) == count_last);
    assign sts.best_is_last = (CW'(best_idx_reg) == count_last);
    assign sts.out_busy = m_valid_reg && !m_ready;

    // write port: shift copies down, or enqueue append at finish
    always_comb begin
        we = 1'b0;
        waddr = rd_tag_reg - IW'(1);
        wdata = rd_data_reg;
        if (cmd.shift && rd_vld_reg) begin
            we = 1'b1;
        end else if (commit && act_reg == ACT_ENQ && !full) begin
            we = 1'b1;
            waddr = count_reg[IW-1:0];
            wdata = {pri_reg, val_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_comb begin
        count_next = count_reg;
        status_next = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (commit) begin
            m_valid_next = 1'b1;
            if (act_reg == ACT_ENQ) begin
                status_next = full ? ST_FULL : ST_ENQ;
                if (!full) begin
                    count_next = count_reg + CW'(1);
                end
            end else begin
                status_next = empty ? ST_EMPTY : ST_DEQ;
                if (!empty) begin
                    count_next = count_last;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (cmd.load_item) begin
            act_reg <= s_action;
            val_reg <= s_value_in;
            pri_reg <= s_priority_in;
            rd_idx_reg <= '0;
        end else if (cmd.setup) begin
            rd_idx_reg <= best_idx_reg + IW'(1);
        end else if (cmd.issue) begin
            rd_idx_reg <= rd_idx_reg + IW'(1);
        end
        if (cmd.issue) begin
            rd_tag_reg <= rd_idx_reg;
        end
        if (take) begin
            best_idx_reg <= rd_tag_reg;
            best_pri_reg <= rd_data_reg[ENTRY_W-1:VALUE_W];
            best_val_reg <= rd_data_reg[VALUE_W-1:0];
        end
        if (commit) begin
            if (act_reg == ACT_DEQ && !empty) begin
                vout_reg <= best_val_reg;
                pout_reg <= best_pri_reg;
            end else begin
                vout_reg <= '0;
                pout_reg <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_value_out = vout_reg;
    assign m_priority_out = pout_reg;

endmodule

// ----- sv/priority_queue_scan_dequeue_top.sv -----
// enqueue, full or empty: from accept straight to the finish state, which registers
// the result word; dequeue: a scan of all entries, then a copy-down of the entries
// behind the winner unless it is the last, then finish, over the entry memory
// one word in flight; a new word is taken while the previous result waits
// reset (aresetn low, synchronous) empties the queue; entry memory is not cleared
module priority_queue_scan_dequeue_top
    import pqsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic signed [VALUE_W-1:0]  s_value_in,
    input  logic        [PRIO_W-1:0]   s_priority_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic        [STATUS_W-1:0] m_status,
    output logic signed [VALUE_W-1:0]  m_value_out,
    output logic        [PRIO_W-1:0]   m_priority_out
);

    cmd_t cmd;
    sts_t sts;

    pqsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pqsd_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_action       (s_action),
        .s_value_in     (s_value_in),
        .s_priority_in  (s_priority_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_value_out    (m_value_out),
        .m_priority_out (m_priority_out),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ----- test/tb_priority_queue_scan_dequeue_top.sv -----
module tb_priority_queue_scan_dequeue_top
    import pqsd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 48;
    localparam int WORDS_PER_PHASE = 107;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } pq_result_t;

    class pq_predictor;
        logic signed [VALUE_W-1:0] slot_val [DEPTH];
        logic [PRIO_W-1:0]         slot_pri [DEPTH];
        int                        fill;
        int                        errors;
        pq_result_t                expected_words [$];

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function void note_word(logic act, logic signed [VALUE_W-1:0] val,
                                logic [PRIO_W-1:0] pri);
            pq_result_t r;
            int best;
            r.status = ST_ENQ;
            r.value = '0;
            r.prio = '0;
            if (act == ACT_ENQ) begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_val[fill] = val;
                    slot_pri[fill] = pri;
                    fill++;
                end
            end else if (fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                // strict compare keeps the earliest among equal priorities
                best = 0;
                for (int i = 1; i < fill; i++) begin
                    if (slot_pri[i] > slot_pri[best]) best = i;
                end
                r.status = ST_DEQ;
                r.value = slot_val[best];
                r.prio = slot_pri[best];
                for (int i = best; i < fill - 1; i++) begin
                    slot_val[i] = slot_val[i + 1];
                    slot_pri[i] = slot_pri[i + 1];
                end
                fill--;
            end
            expected_words.push_back(r);
        endfunction

        function void check_word(logic [STATUS_W-1:0] status,
                                 logic signed [VALUE_W-1:0] val,
                                 logic [PRIO_W-1:0] pri);
            pq_result_t exp;
            if (expected_words.size() == 0) begin
                $error("result word with no expectation: status %0d, value_out %0d, priority_out %0d",
                       status, val, pri);
                errors++;
                return;
            end
            exp = expected_words.pop_front();
            if (status !== exp.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp.status, status);
                errors++;
            end
            if (val !== exp.value) begin
                $error("value_out mismatch: expected %0d, actual %0d", exp.value, val);
                errors++;
            end
            if (pri !== exp.prio) begin
                $error("priority_out mismatch: expected %0d, actual %0d", exp.prio, pri);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_action = ACT_ENQ;
    logic signed [VALUE_W-1:0]  s_value_in = '0;
    logic        [PRIO_W-1:0]   s_priority_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic        [STATUS_W-1:0] m_status;
    logic signed [VALUE_W-1:0]  m_value_out;
    logic        [PRIO_W-1:0]   m_priority_out;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;
    pq_predictor pred = new();

    priority_queue_scan_dequeue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_value_in    (s_value_in),
        .s_priority_in (s_priority_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_value_out   (m_value_out),
        .m_priority_out(m_priority_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) pred.check_word(m_status, m_value_out, m_priority_out);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [PRIO_W-1:0] rand_priority();
        case ($urandom_range(3))
            0: rand_priority = PRIO_W'($urandom_range(3));
            1: rand_priority = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: rand_priority = PRIO_W'($urandom);
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_word(logic act, logic signed [VALUE_W-1:0] val,
                             logic [PRIO_W-1:0] pri);
        int idle;
        idle = 0;
        while (idle < 40 && $urandom_range(99) < send_idle_pct) idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_value_in <= val;
        s_priority_in <= pri;
        do @(posedge aclk); while (!s_ready);
        pred.note_word(act, val, pri);
        @(negedge aclk);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct);
        int sent;
        int burst;
        int enq_pct;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < WORDS_PER_PHASE) begin
            // bursts leaning one way walk the fill level between empty and full
            burst = $urandom_range(24, 4);
            case ($urandom_range(3))
                0: enq_pct = 20;
                1: enq_pct = 50;
                2: enq_pct = 75;
                default: enq_pct = 92;
            endcase
            for (int k = 0; k < burst && sent < WORDS_PER_PHASE; k++) begin
                send_word(($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ, $urandom,
                          rand_priority());
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // dequeue from empty, fields must be ignored
        send_word(ACT_DEQ, 32'sh12345678, 16'hABCD);
        send_word(ACT_ENQ, 32'sh80000000, 16'h0000);
        send_word(ACT_ENQ, 32'sh7FFFFFFF, 16'hFFFF);
        send_word(ACT_ENQ, -32'sd1, 16'hFFFF);
        send_word(ACT_ENQ, 32'sd0, 16'h0000);
        send_word(ACT_ENQ, 32'sd1, 16'h8000);
        send_word(ACT_ENQ, 32'sd2, 16'h7FFF);
        for (int i = 6; i < DEPTH; i++) begin
            send_word(ACT_ENQ, i * 3 - 20, PRIO_W'(i % 3));
        end
        // enqueue into a full queue
        send_word(ACT_ENQ, 32'sh55555555, 16'h1234);
        repeat (5) send_word(ACT_DEQ, 32'shAAAAAAAA, 16'h5A5A);

        run_random_phase(0, 0);
        run_random_phase(74, 0);
        run_random_phase(0, 74);
        run_random_phase(38, 38);

        s_valid <= 1'b0;
        while (pred.expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pred.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
